// ===== hdl/basic_token_scanner_macros.svh =====
// Assertion macros for the basic token scanner checker.
// Included by files that hold concurrent assertions; no other dependencies.
`ifndef BASIC_TOKEN_SCANNER_MACROS_SVH
`define BASIC_TOKEN_SCANNER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BTS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BTS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/bts_pkg.sv =====
// Shared types, constants and token tables for the basic token scanner.
// No dependencies; imported by every module of the block except bts_ram.
package bts_pkg;

   // Word text storage
   localparam int MAX_WORD  = 32;
   localparam int IDX_W     = $clog2(MAX_WORD);
   localparam int LEN_W     = $clog2(MAX_WORD + 1);
   localparam int BUF_AW    = IDX_W + 1;          // one bank bit on top
   localparam int BUF_DEPTH = 2 ** BUF_AW;

   // Flush command queue
   localparam int QUEUE_DEPTH = 4;
   localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   // Line control
   localparam logic [15:0] LIMIT_RESET = 16'd256;

   // Result kinds
   localparam logic [4:0] KIND_UNKNOWN = 5'd0;
   localparam logic [4:0] KIND_NUMBER  = 5'd1;
   localparam logic [4:0] KIND_IDENT   = 5'd2;
   localparam logic [4:0] KIND_OP_BASE = 5'd3;
   localparam logic [4:0] KIND_KW_BASE = 5'd17;

   // Operator and keyword tables (text right-justified, first char highest)
   localparam int NUM_OPS = 14;
   localparam int NUM_KWS = 12;

   localparam logic [15:0] OP_TEXT [NUM_OPS] = '{
      "+", "-", "*", "/", ">", "<", ">=", "<=", "=", "==", "!=", "!", "&&", "||"};
   localparam logic [1:0] OP_LEN [NUM_OPS] = '{
      2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2, 2'd2, 2'd1,
      2'd2, 2'd2};

   localparam logic [63:0] KW_TEXT [NUM_KWS] = '{
      "LABEL", "GOTO", "PRINT", "INPUT", "LET", "IF",
      "THEN", "ELSE", "ENDIF", "WHILE", "REPEAT", "ENDWHILE"};
   localparam logic [3:0] KW_LEN [NUM_KWS] = '{
      4'd5, 4'd4, 4'd5, 4'd5, 4'd3, 4'd2, 4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd8};

   // Token class held by the front end
   typedef enum logic [1:0] {
      CLS_NONE = 2'd0,
      CLS_OP   = 2'd1,
      CLS_NUM  = 2'd2,
      CLS_WORD = 2'd3
   } tok_class_type;

   // One flush of a token, queued from front to back
   typedef struct packed {
      logic             is_text;    // emit buffered characters
      logic [4:0]       kind;
      logic             bank;
      logic [LEN_W-1:0] len;
      logic             overflow;
      logic             last;       // last flush caused by its byte
   } flush_cmd_type;

   // Up to two flushes per byte; valid1 implies valid0
   typedef struct packed {
      logic          valid0;
      logic          valid1;
      flush_cmd_type cmd0;
      flush_cmd_type cmd1;
   } queue_push_type;

   // Back end hands a word bank back to the front end
   typedef struct packed {
      logic valid;
      logic bank;
   } bank_release_type;

   // Word buffer write port
   typedef struct packed {
      logic              en;
      logic [BUF_AW-1:0] addr;
      logic [7:0]        data;
   } ram_write_type;

   // Operator character at position p, zero past its end
   function automatic logic [7:0] op_char(input int i, input logic [LEN_W-1:0] p);
      logic [7:0] r;
      int         sh;
      r  = 8'd0;
      sh = 8 * (int'(OP_LEN[i]) - 1 - int'(p));
      if (int'(p) < int'(OP_LEN[i])) begin
         r = OP_TEXT[i][sh +: 8];
      end
      return r;
   endfunction

   // Keyword character at position p, zero past its end
   function automatic logic [7:0] kw_char(input int i, input logic [LEN_W-1:0] p);
      logic [7:0] r;
      int         sh;
      r  = 8'd0;
      sh = 8 * (int'(KW_LEN[i]) - 1 - int'(p));
      if (int'(p) < int'(KW_LEN[i])) begin
         r = KW_TEXT[i][sh +: 8];
      end
      return r;
   endfunction

endpackage

// ===== hdl/bts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the word text banks of the scanner.
module bts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bts_front.sv =====
// Front end: accepts source bytes, classifies them, tracks the pending token
// and line position, writes word text and queues flushes. Uses bts_pkg.
module bts_front
   import bts_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_ch,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data,
   input  logic             q_room,
   input  bank_release_type release_bank,
   output queue_push_type   push,
   output ram_write_type    ram_wr
);

   tok_class_type      cls_ff, cls_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               ovf_ff, ovf_in;
   logic [NUM_KWS-1:0] kw_ff, kw_in;
   logic [NUM_OPS-1:0] op_ff, op_in;
   logic               bank_ff, bank_in;
   logic [1:0]         busy_ff, busy_in;
   logic [15:0]        pos_ff, pos_in;
   logic               exh_ff, exh_in;
   logic [15:0]        limit_ff, limit_in;

   // Token state after the byte, before a limit flush
   tok_class_type      p_cls;
   logic [LEN_W-1:0]   p_len;
   logic               p_ovf;
   logic [NUM_KWS-1:0] p_kw;
   logic [NUM_OPS-1:0] p_op;
   logic               p_bank;

   tok_class_type      ch_cls;
   logic               accept, is_nul, active, cont, start_text;
   logic               flush1, flush2, lim_hit;
   logic [15:0]        pos_next;
   logic [1:0]         busy_set, busy_clr;
   flush_cmd_type      cmd1, cmd2;

   function automatic tok_class_type classify(input logic [7:0] c);
      tok_class_type r;
      r = CLS_NONE;
      case (c) inside
         // + - * / > < = ! & |
         8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3E, 8'h3C, 8'h3D, 8'h21, 8'h26, 8'h7C: r = CLS_OP;
         [8'h30:8'h39]:                r = CLS_NUM;
         [8'h41:8'h5A], [8'h61:8'h7A]: r = CLS_WORD;
         default:                      r = CLS_NONE;
      endcase
      return r;
   endfunction

   // Resolve a pending token into one flush command
   function automatic flush_cmd_type build_cmd(
      input tok_class_type      cls,
      input logic [LEN_W-1:0]   len,
      input logic               ovf,
      input logic [NUM_KWS-1:0] kwm,
      input logic [NUM_OPS-1:0] opm,
      input logic               bank
   );
      flush_cmd_type r;
      r          = '0;
      r.bank     = bank;
      r.len      = len;
      r.overflow = ovf;
      unique case (cls)
         CLS_OP: begin
            r.kind = KIND_UNKNOWN;
            for (int i = 0; i < NUM_OPS; i++) begin
               if (!ovf && opm[i] && (len == LEN_W'(OP_LEN[i]))) begin
                  r.kind = KIND_OP_BASE + 5'(i);
               end
            end
         end
         CLS_NUM: begin
            r.is_text = 1'b1;
            r.kind    = KIND_NUMBER;
         end
         CLS_WORD: begin
            r.is_text = 1'b1;
            r.kind    = KIND_IDENT;
            for (int i = 0; i < NUM_KWS; i++) begin
               if (!ovf && kwm[i] && (len == LEN_W'(KW_LEN[i]))) begin
                  r.is_text = 1'b0;
                  r.kind    = KIND_KW_BASE + 5'(i);
               end
            end
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   // Byte classification and continuation
   always_comb begin
      is_nul     = (req_ch == 8'd0);
      active     = !is_nul && !exh_ff && (pos_ff < limit_ff);
      ch_cls     = classify(req_ch);
      cont       = active &&
                   (((cls_ff == CLS_OP) && (ch_cls == CLS_OP)) ||
                    ((cls_ff == CLS_NUM) && (ch_cls == CLS_NUM)) ||
                    ((cls_ff == CLS_WORD) && ((ch_cls == CLS_WORD) || (ch_cls == CLS_NUM))));
      start_text = active && !cont && ((ch_cls == CLS_NUM) || (ch_cls == CLS_WORD));
      // a new number or identifier token needs the other bank free
      req_ready  = q_room && !(start_text && busy_ff[~bank_ff]);
      accept     = req_valid && req_ready;
      csr_ready  = 1'b1;
   end

   // Token update, flushes and state
   always_comb begin
      cls_in   = cls_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      kw_in    = kw_ff;
      op_in    = op_ff;
      bank_in  = bank_ff;
      pos_in   = pos_ff;
      exh_in   = exh_ff;
      limit_in = limit_ff;
      ram_wr   = '0;
      push     = '0;
      busy_set = 2'b00;
      busy_clr = 2'b00;

      p_cls  = cls_ff;
      p_len  = len_ff;
      p_ovf  = ovf_ff;
      p_kw   = kw_ff;
      p_op   = op_ff;
      p_bank = bank_ff;

      if (cont) begin
         if (len_ff < LEN_W'(MAX_WORD)) begin
            p_len = len_ff + LEN_W'(1);
            for (int i = 0; i < NUM_KWS; i++) begin
               p_kw[i] = kw_ff[i] && (kw_char(i, len_ff) == req_ch);
            end
            for (int i = 0; i < NUM_OPS; i++) begin
               p_op[i] = op_ff[i] && (op_char(i, len_ff) == req_ch);
            end
            ram_wr.en   = accept && (cls_ff != CLS_OP);
            ram_wr.addr = {bank_ff, len_ff[IDX_W-1:0]};
            ram_wr.data = req_ch;
         end else begin
            p_ovf = 1'b1;
         end
      end else if (active) begin
         p_cls = ch_cls;
         p_len = (ch_cls != CLS_NONE) ? LEN_W'(1) : LEN_W'(0);
         p_ovf = 1'b0;
         for (int i = 0; i < NUM_KWS; i++) begin
            p_kw[i] = (kw_char(i, LEN_W'(0)) == req_ch);
         end
         for (int i = 0; i < NUM_OPS; i++) begin
            p_op[i] = (op_char(i, LEN_W'(0)) == req_ch);
         end
         p_bank      = start_text ? ~bank_ff : bank_ff;
         ram_wr.en   = accept && start_text;
         ram_wr.addr = {~bank_ff, IDX_W'(0)};
         ram_wr.data = req_ch;
      end

      pos_next = pos_ff + 16'd1;
      lim_hit  = active && ((pos_next >= limit_ff) || (pos_next == 16'd0));

      // Flush of the old token, then of the one just built at the limit
      flush1 = accept && (is_nul || (active && !cont)) && (cls_ff != CLS_NONE);
      flush2 = accept && lim_hit && (p_cls != CLS_NONE);
      cmd1   = build_cmd(cls_ff, len_ff, ovf_ff, kw_ff, op_ff, bank_ff);
      cmd2   = build_cmd(p_cls, p_len, p_ovf, p_kw, p_op, p_bank);
      cmd1.last = !flush2;
      cmd2.last = 1'b1;

      if (flush1) begin
         push.valid0 = 1'b1;
         push.cmd0   = cmd1;
         push.valid1 = flush2;
         push.cmd1   = cmd2;
      end else begin
         push.valid0 = flush2;
         push.cmd0   = cmd2;
      end

      if (flush1 && cmd1.is_text) begin
         busy_set[cmd1.bank] = 1'b1;
      end
      if (flush2 && cmd2.is_text) begin
         busy_set[cmd2.bank] = 1'b1;
      end
      if (release_bank.valid) begin
         busy_clr[release_bank.bank] = 1'b1;
      end
      busy_in = (busy_ff & ~busy_clr) | busy_set;

      if (accept) begin
         if (is_nul) begin
            cls_in = CLS_NONE;
            len_in = LEN_W'(0);
            ovf_in = 1'b0;
            pos_in = 16'd0;
            exh_in = 1'b0;
         end else if (active) begin
            pos_in  = pos_next;
            bank_in = p_bank;
            kw_in   = p_kw;
            op_in   = p_op;
            if (lim_hit) begin
               cls_in = CLS_NONE;
               len_in = LEN_W'(0);
               ovf_in = 1'b0;
               exh_in = 1'b1;
            end else begin
               cls_in = p_cls;
               len_in = p_len;
               ovf_in = p_ovf;
            end
         end
      end

      if (csr_valid) begin
         limit_in = csr_data;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cls_ff   <= CLS_NONE;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
         kw_ff    <= '0;
         op_ff    <= '0;
         bank_ff  <= 1'b0;
         busy_ff  <= 2'b00;
         pos_ff   <= 16'd0;
         exh_ff   <= 1'b0;
         limit_ff <= LIMIT_RESET;
      end else begin
         cls_ff   <= cls_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
         kw_ff    <= kw_in;
         op_ff    <= op_in;
         bank_ff  <= bank_in;
         busy_ff  <= busy_in;
         pos_ff   <= pos_in;
         exh_ff   <= exh_in;
         limit_ff <= limit_in;
      end
   end

endmodule

// ===== hdl/bts_queue.sv =====
// Short queue of flush commands between front and back end.
// Takes up to two commands per cycle, hands out one. Uses bts_pkg.
module bts_queue
   import bts_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_push_type push,
   input  logic           pop,
   output logic           room,
   output logic           head_valid,
   output flush_cmd_type  head
);

   flush_cmd_type      slots_ff [QUEUE_DEPTH];
   flush_cmd_type      slots_in [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] cnt_ff, cnt_in;
   logic [Q_CNT_W-1:0] n_push;

   // Pointer and slot update
   always_comb begin
      slots_in = slots_ff;
      n_push   = Q_CNT_W'(push.valid0) + Q_CNT_W'(push.valid1);
      if (push.valid0) begin
         slots_in[wr_ptr_ff] = push.cmd0;
      end
      if (push.valid1) begin
         slots_in[wr_ptr_ff + Q_PTR_W'(1)] = push.cmd1;
      end
      wr_ptr_in = wr_ptr_ff + Q_PTR_W'(n_push);
      rd_ptr_in = pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + n_push - Q_CNT_W'(pop);
   end

   // room for two more commands
   assign room       = (cnt_ff <= Q_CNT_W'(QUEUE_DEPTH - 2));
   assign head_valid = (cnt_ff != '0);
   assign head       = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== hdl/bts_back.sv =====
// Back end: carries out queued flushes, reads word text from the buffer and
// drives the result channel through an output register. Uses bts_pkg.
module bts_back
   import bts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  flush_cmd_type     head,
   output logic              pop,
   output bank_release_type  release_bank,
   output logic              rd_en,
   output logic [BUF_AW-1:0] rd_addr,
   input  logic [7:0]        rd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [4:0]        rsp_kind,
   output logic [7:0]        rsp_text_char,
   output logic              rsp_token_end,
   output logic              rsp_text_overflow,
   output logic              rsp_burst_last
);

   typedef struct packed {
      logic       is_text;
      logic [4:0] kind;
      logic       token_end;
      logic       overflow;
      logic       last;
   } result_meta_type;

   logic             have_ff, have_in;
   flush_cmd_type    cmd_ff, cmd_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             p_valid_ff, p_valid_in;
   result_meta_type  p_meta_ff, p_meta_in;
   logic             o_valid_ff, o_valid_in;
   logic [4:0]       o_kind_ff, o_kind_in;
   logic [7:0]       o_char_ff, o_char_in;
   logic             o_end_ff, o_end_in;
   logic             o_ovf_ff, o_ovf_in;
   logic             o_last_ff, o_last_in;

   logic o_free, p_move, issue, is_end;

   // Issue one result per cycle while the output is not stalled: read stage, then output register
   always_comb begin
      o_free = !o_valid_ff || rsp_ready;
      p_move = p_valid_ff && o_free;
      issue  = have_ff && (!p_valid_ff || o_free);
      is_end = !cmd_ff.is_text || (idx_ff == (cmd_ff.len - LEN_W'(1)));
      pop    = head_valid && (!have_ff || (issue && is_end));

      rd_en   = issue && cmd_ff.is_text;
      rd_addr = {cmd_ff.bank, idx_ff[IDX_W-1:0]};

      release_bank.valid = issue && is_end && cmd_ff.is_text;
      release_bank.bank  = cmd_ff.bank;

      // command sequencing
      have_in = have_ff;
      cmd_in  = cmd_ff;
      idx_in  = idx_ff;
      if (pop) begin
         have_in = 1'b1;
         cmd_in  = head;
         idx_in  = LEN_W'(0);
      end else if (issue && is_end) begin
         have_in = 1'b0;
      end else if (issue) begin
         idx_in = idx_ff + LEN_W'(1);
      end

      // read stage
      p_valid_in = p_valid_ff;
      p_meta_in  = p_meta_ff;
      if (issue) begin
         p_valid_in          = 1'b1;
         p_meta_in.is_text   = cmd_ff.is_text;
         p_meta_in.kind      = cmd_ff.kind;
         p_meta_in.token_end = is_end;
         p_meta_in.overflow  = cmd_ff.overflow;
         p_meta_in.last      = is_end && cmd_ff.last;
      end else if (p_move) begin
         p_valid_in = 1'b0;
      end

      // output register
      o_valid_in = o_valid_ff;
      o_kind_in  = o_kind_ff;
      o_char_in  = o_char_ff;
      o_end_in   = o_end_ff;
      o_ovf_in   = o_ovf_ff;
      o_last_in  = o_last_ff;
      if (p_move) begin
         o_valid_in = 1'b1;
         o_kind_in  = p_meta_ff.kind;
         o_char_in  = p_meta_ff.is_text ? rd_data : 8'd0;
         o_end_in   = p_meta_ff.token_end;
         o_ovf_in   = p_meta_ff.overflow;
         o_last_in  = p_meta_ff.last;
      end else if (rsp_ready) begin
         o_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff    <= 1'b0;
         p_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         have_ff    <= have_in;
         p_valid_ff <= p_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      idx_ff    <= idx_in;
      p_meta_ff <= p_meta_in;
      o_kind_ff <= o_kind_in;
      o_char_ff <= o_char_in;
      o_end_ff  <= o_end_in;
      o_ovf_ff  <= o_ovf_in;
      o_last_ff <= o_last_in;
   end

   assign rsp_valid         = o_valid_ff;
   assign rsp_kind          = o_kind_ff;
   assign rsp_text_char     = o_char_ff;
   assign rsp_token_end     = o_end_ff;
   assign rsp_text_overflow = o_ovf_ff;
   assign rsp_burst_last    = o_last_ff;

endmodule

// ===== hdl/basic_token_scanner.sv =====
// Basic token scanner: source bytes in, token results out. The front end takes
// one byte per cycle whenever the flush queue has room for two commands and,
// for a byte that opens a number or identifier, the other of the two word
// banks in the text RAM has been handed back. The back end sends one result
// per cycle unless rsp_ready stalls it, so a number or identifier gives one
// result per stored character (at most MAX_WORD, longer runs are cut) and an
// operator or keyword one result; a flush from the queue passes the command
// register, the read stage and the output register. The text RAM needs no
// clearing pass after reset: only characters written for the current token
// are read. Depends on bts_pkg, bts_front, bts_queue, bts_back and bts_ram.
module basic_token_scanner
   import bts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_kind,
   output logic [7:0]  rsp_text_char,
   output logic        rsp_token_end,
   output logic        rsp_text_overflow,
   output logic        rsp_burst_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   queue_push_type    push;
   bank_release_type  release_bank;
   ram_write_type     ram_wr;
   flush_cmd_type     head;
   logic              q_room, head_valid, pop;
   logic              rd_en;
   logic [BUF_AW-1:0] rd_addr;
   logic [7:0]        rd_data;

   // Byte intake and token tracking
   bts_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_ch       (req_ch),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .q_room       (q_room),
      .release_bank (release_bank),
      .push         (push),
      .ram_wr       (ram_wr)
   );

   // Flush commands
   bts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .room       (q_room),
      .head_valid (head_valid),
      .head       (head)
   );

   // Two banks of word text
   bts_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH)
   ) u_text_ram (
      .clock   (clock),
      .wr_en   (ram_wr.en),
      .wr_addr (ram_wr.addr),
      .wr_data (ram_wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Result generation
   bts_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head              (head),
      .pop               (pop),
      .release_bank      (release_bank),
      .rd_en             (rd_en),
      .rd_addr           (rd_addr),
      .rd_data           (rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_text_char     (rsp_text_char),
      .rsp_token_end     (rsp_token_end),
      .rsp_text_overflow (rsp_text_overflow),
      .rsp_burst_last    (rsp_burst_last)
   );

endmodule

// ===== hdl/bts_checker.sv =====
// Port-level checker for the basic token scanner, bound to the top level.
// Depends on bts_pkg and basic_token_scanner_macros.svh.
`include "basic_token_scanner_macros.svh"

module bts_checker
   import bts_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [4:0] rsp_kind,
   input logic [7:0] rsp_text_char,
   input logic       rsp_token_end,
   input logic       rsp_text_overflow,
   input logic       rsp_burst_last
);

   // a stalled result holds
   `BTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_text_char) && $stable(rsp_token_end) && $stable(rsp_text_overflow) && $stable(rsp_burst_last), "result changed while stalled")

   // result kinds stay within the defined codes
   `BTS_ASSERT_IMPL(a_kind_range, clock, reset, rsp_valid, rsp_kind <= KIND_KW_BASE + 5'(NUM_KWS - 1), "result kind out of range")

   // only number and identifier results carry text
   `BTS_ASSERT_IMPL(a_no_text, clock, reset, rsp_valid && rsp_kind != KIND_NUMBER && rsp_kind != KIND_IDENT, rsp_text_char == 8'd0 && rsp_token_end, "single result token with text or open end")

   // the last result of a request closes a token
   `BTS_ASSERT_IMPL(a_last_ends, clock, reset, rsp_valid && rsp_burst_last, rsp_token_end, "request ended inside a token")

endmodule

bind basic_token_scanner bts_checker u_bts_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_kind          (rsp_kind),
   .rsp_text_char     (rsp_text_char),
   .rsp_token_end     (rsp_token_end),
   .rsp_text_overflow (rsp_text_overflow),
   .rsp_burst_last    (rsp_burst_last)
);
